### rtl/tdfe_pkg.sv
// shared types, constants and helpers of the table driven fsm engine
// depends on nothing; used by tdfe_seq and the top level by scoped names
`timescale 1ns / 1ps

package tdfe_pkg;

	// table geometry, fixed by the payload widths
	localparam int unsigned ST_DEPTH = 16;
	localparam int unsigned ST_AW = 4;
	localparam int unsigned TR_DEPTH = 64;
	localparam int unsigned TR_AW = 6;
	localparam int unsigned NUM_GUARDS = 16;
	localparam int unsigned MAX_PER_STATE_DEF = 8;

	// beat codes of the input channel
	localparam logic [2:0] MODE_EVENT = 3'd0;
	localparam logic [2:0] MODE_LOAD_ST = 3'd1;
	localparam logic [2:0] MODE_LOAD_TR = 3'd2;
	localparam logic [2:0] MODE_LOAD_ACT = 3'd3;
	localparam logic [2:0] MODE_SET = 3'd4;

	// beat codes of the output channel
	localparam logic [2:0] KIND_ACK = 3'd0;
	localparam logic [2:0] KIND_EXIT = 3'd1;
	localparam logic [2:0] KIND_TRANS = 3'd2;
	localparam logic [2:0] KIND_ENTRY = 3'd3;
	localparam logic [2:0] KIND_STATUS = 3'd4;

	localparam logic [1:0] STS_OK = 2'd0;
	localparam logic [1:0] STS_ABSENT = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;

	typedef struct packed {
		logic present;
		logic [TR_AW-1:0] base;
		logic [3:0] count;
	} st_entry_t;

	typedef struct packed {
		logic [3:0] event_code;
		logic [4:0] guard;
		logic [7:0] action;
		logic [3:0] target;
	} tr_entry_t;

	typedef struct packed {
		logic [7:0] entry_act;
		logic [7:0] exit_act;
	} act_entry_t;

	// read requests from the sequencer to the table memories
	typedef struct packed {
		logic st_re;
		logic [ST_AW-1:0] st_addr;
		logic ac_re;
		logic [ST_AW-1:0] ac_addr;
		logic tr_re;
		logic [TR_AW-1:0] tr_addr;
	} rd_req_t;

	// read data back, never-written state and action entries already masked
	typedef struct packed {
		logic st_present;
		logic [TR_AW-1:0] st_base;
		logic [3:0] st_count;
		logic [7:0] ac_entry;
		logic [7:0] ac_exit;
		logic [3:0] tr_event;
		logic [4:0] tr_guard;
		logic [7:0] tr_action;
		logic [3:0] tr_target;
	} rd_data_t;

	// guard zero always passes, unknown guard ids never do
	function automatic logic guard_ok(input logic [4:0] g, input logic [15:0] flags);
		logic r;
		r = 1'b0;
		if (g == 5'd0) begin
			r = 1'b1;
		end else if (g <= 5'(NUM_GUARDS)) begin
			r = flags[4'(g - 5'd1)];
		end
		return r;
	endfunction

endpackage

### rtl/tdfe_ram.sv
// generic single write port, single read port ram with registered read data
// depends on nothing
`timescale 1ns / 1ps

module tdfe_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/tdfe_seq.sv
// event sequencer: state lookup, two walks over the transition entries,
// action emission and the output register; uses tdfe_pkg
`timescale 1ns / 1ps

module tdfe_seq #(
	parameter int unsigned MAX_PER_STATE = tdfe_pkg::MAX_PER_STATE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          mode,
	input  logic [3:0]          event_req,
	input  logic [3:0]          state_id,
	input  logic [15:0]         guard_flags,
	output tdfe_pkg::rd_req_t   rd_req,
	input  tdfe_pkg::rd_data_t  rd,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          kind,
	output logic [7:0]          action_id,
	output logic [1:0]          status,
	output logic [3:0]          new_state,
	output logic                last
);

	localparam int unsigned CAP = (MAX_PER_STATE < 15) ? MAX_PER_STATE : 15;
	localparam logic [3:0] CAP_N = 4'(CAP);

	localparam logic [1:0] PH_EXIT = 2'd0;
	localparam logic [1:0] PH_TRANS = 2'd1;
	localparam logic [1:0] PH_ENTRY = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ACK,
		S_LOOKUP,
		S_EXIT,
		S_SCAN,
		S_WALK,
		S_ENTRY,
		S_EMIT,
		S_STATUS
	} fsm_t;

	fsm_t state_q;
	logic [3:0] cur_q;
	logic [3:0] fin_q;
	logic [3:0] ev_q;
	logic [15:0] flags_q;
	logic [tdfe_pkg::TR_AW-1:0] base_q;
	logic [3:0] n_q;
	logic [3:0] i_q;
	logic [1:0] ph_q;
	logic [1:0] sts_q;
	logic [7:0] exit_q;
	logic [7:0] act_q;
	logic [7:0] entry_q;

	logic out_valid_q;
	logic [2:0] kind_q;
	logic [7:0] action_q;
	logic [1:0] status_q;
	logic [3:0] new_state_q;
	logic last_q;

	logic acc;
	logic out_free;
	logic out_load;
	logic match;
	logic i_last;
	logic [3:0] i_nx;
	logic [tdfe_pkg::TR_AW-1:0] nxt_addr;
	logic [3:0] n_eff;
	logic [7:0] em_val;
	logic [2:0] em_kind;
	logic em_adv;
	logic fin_match;

	assign in_stall = (state_q != S_IDLE);
	assign acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign match = (rd.tr_event == ev_q) && tdfe_pkg::guard_ok(rd.tr_guard, flags_q);
	assign i_last = (i_q == n_q - 4'd1);
	assign i_nx = i_q + 4'd1;
	assign nxt_addr = base_q + tdfe_pkg::TR_AW'(i_nx);
	assign n_eff = (rd.st_count > CAP_N) ? CAP_N : rd.st_count;

	// action of the current emission phase, zero ids are skipped
	always_comb begin
		case (ph_q)
			PH_EXIT: begin
				em_val = exit_q;
				em_kind = tdfe_pkg::KIND_EXIT;
			end
			PH_TRANS: begin
				em_val = act_q;
				em_kind = tdfe_pkg::KIND_TRANS;
			end
			default: begin
				em_val = entry_q;
				em_kind = tdfe_pkg::KIND_ENTRY;
			end
		endcase
	end

	assign em_adv = (em_val == 8'd0) || out_free;
	assign fin_match = (ph_q == PH_ENTRY) && em_adv;

	// a new beat enters the output register
	assign out_load = out_free && ((state_q == S_ACK) || (state_q == S_STATUS)
		|| ((state_q == S_EMIT) && (em_val != 8'd0)));

	// memory read requests
	always_comb begin
		rd_req = '0;
		rd_req.st_addr = cur_q;
		rd_req.ac_addr = cur_q;
		rd_req.tr_addr = nxt_addr;
		case (state_q)
			S_IDLE: begin
				rd_req.st_re = acc && (mode == tdfe_pkg::MODE_EVENT);
			end
			S_LOOKUP: begin
				rd_req.ac_re = rd.st_present && (rd.st_count != 4'd0);
			end
			S_EXIT: begin
				rd_req.tr_re = 1'b1;
				rd_req.tr_addr = base_q;
			end
			S_SCAN: begin
				rd_req.tr_re = 1'b1;
				if (i_last) begin
					rd_req.tr_addr = base_q;
				end
			end
			S_WALK: begin
				if (match) begin
					rd_req.ac_re = 1'b1;
					rd_req.ac_addr = rd.tr_target;
				end else begin
					rd_req.tr_re = !i_last;
				end
			end
			S_EMIT: begin
				rd_req.tr_re = fin_match && !i_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q <= '0;
			fin_q <= '0;
			ev_q <= '0;
			flags_q <= '0;
			base_q <= '0;
			n_q <= '0;
			i_q <= '0;
			ph_q <= PH_EXIT;
			sts_q <= tdfe_pkg::STS_OK;
			exit_q <= '0;
			act_q <= '0;
			entry_q <= '0;
			out_valid_q <= 1'b0;
			kind_q <= tdfe_pkg::KIND_ACK;
			action_q <= '0;
			status_q <= tdfe_pkg::STS_OK;
			new_state_q <= '0;
			last_q <= 1'b0;
		end else begin
			// output register: load a new beat or let the taken one go
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						ev_q <= event_req;
						flags_q <= guard_flags;
						fin_q <= cur_q;
						sts_q <= tdfe_pkg::STS_OK;
						if (mode == tdfe_pkg::MODE_EVENT) begin
							state_q <= S_LOOKUP;
						end else begin
							if (mode == tdfe_pkg::MODE_SET) begin
								cur_q <= state_id;
							end
							state_q <= S_ACK;
						end
					end
				end
				S_ACK: begin
					if (out_free) begin
						kind_q <= tdfe_pkg::KIND_ACK;
						action_q <= '0;
						status_q <= tdfe_pkg::STS_OK;
						new_state_q <= cur_q;
						last_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_LOOKUP: begin
					base_q <= rd.st_base;
					n_q <= n_eff;
					if (!rd.st_present) begin
						sts_q <= tdfe_pkg::STS_ABSENT;
						state_q <= S_STATUS;
					end else if (rd.st_count == 4'd0) begin
						sts_q <= tdfe_pkg::STS_EMPTY;
						state_q <= S_STATUS;
					end else begin
						state_q <= S_EXIT;
					end
				end
				S_EXIT: begin
					exit_q <= rd.ac_exit;
					i_q <= '0;
					state_q <= S_SCAN;
				end
				// first walk: find the state the last match leads to
				S_SCAN: begin
					if (match) begin
						fin_q <= rd.tr_target;
					end
					if (i_last) begin
						i_q <= '0;
						state_q <= S_WALK;
					end else begin
						i_q <= i_nx;
					end
				end
				// second walk: emit the actions of every match
				S_WALK: begin
					if (match) begin
						act_q <= rd.tr_action;
						state_q <= S_ENTRY;
					end else if (i_last) begin
						state_q <= S_STATUS;
					end else begin
						i_q <= i_nx;
					end
				end
				S_ENTRY: begin
					entry_q <= rd.ac_entry;
					ph_q <= PH_EXIT;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if ((em_val != 8'd0) && out_free) begin
						kind_q <= em_kind;
						action_q <= em_val;
						status_q <= tdfe_pkg::STS_OK;
						new_state_q <= fin_q;
						last_q <= 1'b0;
					end
					if (em_adv) begin
						if (ph_q != PH_ENTRY) begin
							ph_q <= ph_q + 2'd1;
						end else if (i_last) begin
							state_q <= S_STATUS;
						end else begin
							i_q <= i_nx;
							state_q <= S_WALK;
						end
					end
				end
				S_STATUS: begin
					if (out_free) begin
						kind_q <= tdfe_pkg::KIND_STATUS;
						action_q <= '0;
						status_q <= sts_q;
						new_state_q <= fin_q;
						last_q <= 1'b1;
						cur_q <= fin_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign action_id = action_q;
	assign status = status_q;
	assign new_state = new_state_q;
	assign last = last_q;

endmodule

### rtl/table_driven_fsm_engine.sv
// a load or set-state beat is acked through the ack state and the output register
// an event looks up its state, walks up to MAX_PER_STATE (at most 15) transitions
// twice and emits the actions of each match; output stalls hold it up
// one beat is in work at a time; output register frees the input side
// reset: arst_n clears current state, all state entries absent, all actions zero
`timescale 1ns / 1ps

// top level: state table, transition store and action store rams, the valid
// bits that stand for the state and action rams' reset, and the event sequencer
// depends on tdfe_pkg, tdfe_ram, tdfe_seq

module table_driven_fsm_engine #(
	parameter int unsigned MAX_PER_STATE = tdfe_pkg::MAX_PER_STATE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [3:0]  event_req,
	input  logic [3:0]  state_id,
	input  logic        present,
	input  logic [5:0]  index,
	input  logic [3:0]  count,
	input  logic [4:0]  guard_id,
	input  logic [7:0]  action_a,
	input  logic [7:0]  action_b,
	input  logic [3:0]  to_state,
	input  logic [15:0] guard_flags,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  action_id,
	output logic [1:0]  status,
	output logic [3:0]  new_state,
	output logic        last
);

	logic acc;
	logic st_we;
	logic tr_we;
	logic ac_we;

	tdfe_pkg::rd_req_t rd_req;
	tdfe_pkg::rd_data_t rd;
	tdfe_pkg::st_entry_t st_wdata;
	tdfe_pkg::st_entry_t st_rdata;
	tdfe_pkg::tr_entry_t tr_wdata;
	tdfe_pkg::tr_entry_t tr_rdata;
	tdfe_pkg::act_entry_t ac_wdata;
	tdfe_pkg::act_entry_t ac_rdata;

	// one valid bit per state and action entry: a cleared bit reads as reset value
	logic [tdfe_pkg::ST_DEPTH-1:0] st_vld_q;
	logic [tdfe_pkg::ST_DEPTH-1:0] ac_vld_q;
	logic st_hit_s1;
	logic ac_hit_s1;

	assign acc = in_valid && !in_stall;

	// loads write their table on the accepting edge
	assign st_we = acc && (mode == tdfe_pkg::MODE_LOAD_ST);
	assign tr_we = acc && (mode == tdfe_pkg::MODE_LOAD_TR);
	assign ac_we = acc && (mode == tdfe_pkg::MODE_LOAD_ACT);

	assign st_wdata.present = present;
	assign st_wdata.base = index;
	assign st_wdata.count = count;

	assign tr_wdata.event_code = event_req;
	assign tr_wdata.guard = guard_id;
	assign tr_wdata.action = action_a;
	assign tr_wdata.target = to_state;

	assign ac_wdata.entry_act = action_a;
	assign ac_wdata.exit_act = action_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_vld_q <= '0;
			ac_vld_q <= '0;
			st_hit_s1 <= 1'b0;
			ac_hit_s1 <= 1'b0;
		end else begin
			if (st_we) begin
				st_vld_q[state_id] <= 1'b1;
			end
			if (ac_we) begin
				ac_vld_q[state_id] <= 1'b1;
			end
			// valid bit is registered on the ram's read enable, in step with its read data
			if (rd_req.st_re) begin
				st_hit_s1 <= st_vld_q[rd_req.st_addr];
			end
			if (rd_req.ac_re) begin
				ac_hit_s1 <= ac_vld_q[rd_req.ac_addr];
			end
		end
	end

	tdfe_ram #(
		.WIDTH($bits(tdfe_pkg::st_entry_t)),
		.DEPTH(tdfe_pkg::ST_DEPTH)
	) u_st_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(state_id),
		.wdata(st_wdata),
		.re   (rd_req.st_re),
		.raddr(rd_req.st_addr),
		.rdata(st_rdata)
	);

	// no transition store reset; user, not rtl, keeps never-written entries unread
	tdfe_ram #(
		.WIDTH($bits(tdfe_pkg::tr_entry_t)),
		.DEPTH(tdfe_pkg::TR_DEPTH)
	) u_tr_ram (
		.clk  (clk),
		.we   (tr_we),
		.waddr(index),
		.wdata(tr_wdata),
		.re   (rd_req.tr_re),
		.raddr(rd_req.tr_addr),
		.rdata(tr_rdata)
	);

	tdfe_ram #(
		.WIDTH($bits(tdfe_pkg::act_entry_t)),
		.DEPTH(tdfe_pkg::ST_DEPTH)
	) u_ac_ram (
		.clk  (clk),
		.we   (ac_we),
		.waddr(state_id),
		.wdata(ac_wdata),
		.re   (rd_req.ac_re),
		.raddr(rd_req.ac_addr),
		.rdata(ac_rdata)
	);

	// masked read data toward the sequencer
	assign rd.st_present = st_hit_s1 && st_rdata.present;
	assign rd.st_base = st_rdata.base;
	assign rd.st_count = st_rdata.count;
	assign rd.ac_entry = ac_hit_s1 ? ac_rdata.entry_act : 8'd0;
	assign rd.ac_exit = ac_hit_s1 ? ac_rdata.exit_act : 8'd0;
	assign rd.tr_event = tr_rdata.event_code;
	assign rd.tr_guard = tr_rdata.guard;
	assign rd.tr_action = tr_rdata.action;
	assign rd.tr_target = tr_rdata.target;

	tdfe_seq #(
		.MAX_PER_STATE(MAX_PER_STATE)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.event_req  (event_req),
		.state_id   (state_id),
		.guard_flags(guard_flags),
		.rd_req     (rd_req),
		.rd         (rd),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.action_id  (action_id),
		.status     (status),
		.new_state  (new_state),
		.last       (last)
	);

`ifndef NO_ASSERTIONS
	// an error status only ever comes on the closing status beat
	a_status_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != tdfe_pkg::STS_OK)) |->
		((kind == tdfe_pkg::KIND_STATUS) && last))
		else $error("error status outside a closing status beat");

	// only acks and status beats close an item
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |->
		((kind == tdfe_pkg::KIND_ACK) || (kind == tdfe_pkg::KIND_STATUS)))
		else $error("action beat marked last");

	// every taken beat keeps the input stalled in the next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> in_stall)
		else $error("input taken while an item is in work");

	// the sequencer never reads a table in the cycle a load writes it
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!((rd_req.st_re && st_we) || (rd_req.tr_re && tr_we) || (rd_req.ac_re && ac_we)))
		else $error("table read overlaps a load");
`endif

endmodule

### tb/tb_table_driven_fsm_engine.sv
`timescale 1ns / 1ps
// self-checking testbench of the table driven fsm engine: directed and random beats
// with a scoreboard class that predicts every output beat; depends on tdfe_pkg and the rtl

module tb_table_driven_fsm_engine;
	import tdfe_pkg::*;

	// run limits
	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned DRAIN_CYCLES = 100;
	localparam int unsigned RANDOM_BEATS = 200;

	// modes the block acks without doing anything
	localparam logic [2:0] MODE_SPARE_LO = 3'd5;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	// one input beat, all fields side by side
	typedef struct packed {
		logic [2:0]  mode;
		logic [3:0]  event_req;
		logic [3:0]  state_id;
		logic        present;
		logic [5:0]  index;
		logic [3:0]  count;
		logic [4:0]  guard_id;
		logic [7:0]  action_a;
		logic [7:0]  action_b;
		logic [3:0]  to_state;
		logic [15:0] guard_flags;
	} beat_t;

	// one output beat
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] action_id;
		logic [1:0] status;
		logic [3:0] new_state;
		logic       last;
	} out_beat_t;

	// shadow copy of the engine tables plus the queue of output beats still due
	class fsm_scoreboard;
		logic [3:0] cur_state;
		st_entry_t  st_tab [ST_DEPTH];
		tr_entry_t  tr_mem [TR_DEPTH];
		bit         tr_written [TR_DEPTH];
		act_entry_t act_tab [ST_DEPTH];
		out_beat_t  pending_beats [$];
		int unsigned errors;

		function new();
			cur_state = '0;
			errors = 0;
			foreach (st_tab[i]) begin
				st_tab[i] = '0;
				act_tab[i] = '0;
			end
			foreach (tr_mem[i]) begin
				tr_mem[i] = '0;
				tr_written[i] = 1'b0;
			end
		endfunction

		function int pending();
			return pending_beats.size();
		endfunction

		function bit guard_passes(logic [4:0] g, logic [15:0] flags);
			if (g == 5'd0) begin
				return 1'b1;
			end
			if (g > 5'(NUM_GUARDS)) begin
				return 1'b0;
			end
			return flags[4'(g - 5'd1)];
		endfunction

		function int hop_count(logic [3:0] cnt);
			if (cnt > 4'(MAX_PER_STATE_DEF)) begin
				return MAX_PER_STATE_DEF;
			end
			return cnt;
		endfunction

		// first transition address the next event would read before it was ever written
		function int first_unwritten_hop();
			st_entry_t se;
			logic [5:0] a;
			int i;
			se = st_tab[cur_state];
			if (!se.present) begin
				return -1;
			end
			for (i = 0; i < hop_count(se.count); i++) begin
				a = se.base + 6'(i);
				if (!tr_written[a]) begin
					return int'(a);
				end
			end
			return -1;
		endfunction

		function void push(logic [2:0] k, logic [7:0] act, logic [1:0] sts, logic lst);
			out_beat_t o;
			o.kind = k;
			o.action_id = act;
			o.status = sts;
			o.new_state = cur_state;
			o.last = lst;
			pending_beats.push_back(o);
		endfunction

		// walk the transitions of the current state for one event
		function void step_event(logic [3:0] ev, logic [15:0] flags);
			st_entry_t se;
			tr_entry_t t;
			logic [3:0] start;
			logic [3:0] next;
			logic [5:0] a;
			int i;
			int first;
			start = cur_state;
			se = st_tab[start];
			if (!se.present) begin
				push(KIND_STATUS, 8'd0, STS_ABSENT, 1'b1);
				return;
			end
			if (se.count == 4'd0) begin
				push(KIND_STATUS, 8'd0, STS_EMPTY, 1'b1);
				return;
			end
			next = start;
			first = pending_beats.size();
			for (i = 0; i < hop_count(se.count); i++) begin
				a = se.base + 6'(i);
				t = tr_mem[a];
				if (t.event_code == ev && guard_passes(t.guard, flags)) begin
					if (act_tab[start].exit_act != 8'd0) begin
						push(KIND_EXIT, act_tab[start].exit_act, STS_OK, 1'b0);
					end
					if (t.action != 8'd0) begin
						push(KIND_TRANS, t.action, STS_OK, 1'b0);
					end
					if (act_tab[t.target].entry_act != 8'd0) begin
						push(KIND_ENTRY, act_tab[t.target].entry_act, STS_OK, 1'b0);
					end
					next = t.target;
				end
			end
			// every beat of the event carries the state it ends in
			cur_state = next;
			for (i = first; i < pending_beats.size(); i++) begin
				pending_beats[i].new_state = next;
			end
			push(KIND_STATUS, 8'd0, STS_OK, 1'b1);
		endfunction

		// update the shadow tables for an accepted input beat
		function void absorb_input(beat_t b);
			case (b.mode)
				MODE_EVENT: begin
					step_event(b.event_req, b.guard_flags);
				end
				MODE_LOAD_ST: begin
					st_tab[b.state_id].present = b.present;
					st_tab[b.state_id].base = b.index;
					st_tab[b.state_id].count = b.count;
					push(KIND_ACK, 8'd0, STS_OK, 1'b1);
				end
				MODE_LOAD_TR: begin
					tr_mem[b.index].event_code = b.event_req;
					tr_mem[b.index].guard = b.guard_id;
					tr_mem[b.index].action = b.action_a;
					tr_mem[b.index].target = b.to_state;
					tr_written[b.index] = 1'b1;
					push(KIND_ACK, 8'd0, STS_OK, 1'b1);
				end
				MODE_LOAD_ACT: begin
					act_tab[b.state_id].entry_act = b.action_a;
					act_tab[b.state_id].exit_act = b.action_b;
					push(KIND_ACK, 8'd0, STS_OK, 1'b1);
				end
				MODE_SET: begin
					cur_state = b.state_id;
					push(KIND_ACK, 8'd0, STS_OK, 1'b1);
				end
				default: begin
					push(KIND_ACK, 8'd0, STS_OK, 1'b1);
				end
			endcase
		endfunction

		function void check_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		// compare an accepted output beat with the oldest one due
		function void match_output(out_beat_t got);
			out_beat_t want;
			if (pending_beats.size() == 0) begin
				$display("%0t: output beat with none due: expected nothing, actual kind %0d act %0d",
					$time, got.kind, got.action_id);
				errors++;
				return;
			end
			want = pending_beats.pop_front();
			check_field("kind", 8'(want.kind), 8'(got.kind));
			check_field("action_id", want.action_id, got.action_id);
			check_field("status", 8'(want.status), 8'(got.status));
			check_field("new_state", 8'(want.new_state), 8'(got.new_state));
			check_field("last", 8'(want.last), 8'(got.last));
		endfunction
	endclass

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// input channel
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  mode = '0;
	logic [3:0]  event_req = '0;
	logic [3:0]  state_id = '0;
	logic        present = 1'b0;
	logic [5:0]  index = '0;
	logic [3:0]  count = '0;
	logic [4:0]  guard_id = '0;
	logic [7:0]  action_a = '0;
	logic [7:0]  action_b = '0;
	logic [3:0]  to_state = '0;
	logic [15:0] guard_flags = '0;

	// output channel
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  action_id;
	logic [1:0]  status;
	logic [3:0]  new_state;
	logic        last;

	fsm_scoreboard sb;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned beats_sent = 0;
	int unsigned cycle_count = 0;

	table_driven_fsm_engine DUT (.*);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hard stop if the run hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("table_driven_fsm_engine test failed");
			$finish;
		end
	end

	// receiver: check the beat taken at this edge, then pick the stall for the next one
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			sb.match_output('{kind, action_id, status, new_state, last});
		end
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// random junk everywhere, callers overwrite the fields that matter
	function automatic beat_t noise_beat();
		beat_t b;
		b.mode = 3'($urandom);
		b.event_req = 4'($urandom);
		b.state_id = 4'($urandom);
		b.present = 1'($urandom);
		b.index = 6'($urandom);
		b.count = 4'($urandom);
		b.guard_id = 5'($urandom);
		b.action_a = 8'($urandom);
		b.action_b = 8'($urandom);
		b.to_state = 4'($urandom);
		b.guard_flags = 16'($urandom);
		return b;
	endfunction

	// mostly a handful of states so the tables get reused, sometimes any state
	function automatic logic [3:0] pick_state();
		if ($urandom_range(0, 99) < 80) begin
			return 4'($urandom_range(0, 5));
		end
		return 4'($urandom);
	endfunction

	function automatic logic [3:0] pick_event();
		if ($urandom_range(0, 99) < 75) begin
			return 4'($urandom_range(0, 3));
		end
		return 4'($urandom);
	endfunction

	// zero means no action
	function automatic logic [7:0] pick_action();
		if ($urandom_range(0, 99) < 25) begin
			return 8'd0;
		end
		return 8'($urandom_range(1, 255));
	endfunction

	// no guard, a known guard, or an id past the last guard
	function automatic logic [4:0] pick_guard();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			return 5'd0;
		end else if (r < 90) begin
			return 5'($urandom_range(1, NUM_GUARDS));
		end
		return 5'($urandom_range(NUM_GUARDS + 1, 31));
	endfunction

	function automatic logic [15:0] pick_flags();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			return 16'hFFFF;
		end else if (r < 25) begin
			return 16'h0000;
		end
		return 16'($urandom);
	endfunction

	// hold the beat until the block takes it; valid stays up into the next beat
	task automatic send_beat(beat_t b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= b.mode;
		event_req <= b.event_req;
		state_id <= b.state_id;
		present <= b.present;
		index <= b.index;
		count <= b.count;
		guard_id <= b.guard_id;
		action_a <= b.action_a;
		action_b <= b.action_b;
		to_state <= b.to_state;
		guard_flags <= b.guard_flags;
		@(posedge clk);
		while (in_stall !== 1'b0) begin
			@(posedge clk);
		end
		sb.absorb_input(b);
		beats_sent++;
	endtask

	task automatic load_state(logic [3:0] sid, logic pres, logic [5:0] base, logic [3:0] cnt);
		beat_t b;
		b = noise_beat();
		b.mode = MODE_LOAD_ST;
		b.state_id = sid;
		b.present = pres;
		b.index = base;
		b.count = cnt;
		send_beat(b);
	endtask

	task automatic load_trans(logic [5:0] addr, logic [3:0] ev, logic [4:0] gid,
			logic [7:0] act, logic [3:0] tgt);
		beat_t b;
		b = noise_beat();
		b.mode = MODE_LOAD_TR;
		b.index = addr;
		b.event_req = ev;
		b.guard_id = gid;
		b.action_a = act;
		b.to_state = tgt;
		send_beat(b);
	endtask

	task automatic load_actions(logic [3:0] sid, logic [7:0] en_act, logic [7:0] ex_act);
		beat_t b;
		b = noise_beat();
		b.mode = MODE_LOAD_ACT;
		b.state_id = sid;
		b.action_a = en_act;
		b.action_b = ex_act;
		send_beat(b);
	endtask

	task automatic set_state(logic [3:0] sid);
		beat_t b;
		b = noise_beat();
		b.mode = MODE_SET;
		b.state_id = sid;
		send_beat(b);
	endtask

	task automatic send_spare(logic [2:0] m);
		beat_t b;
		b = noise_beat();
		b.mode = m;
		send_beat(b);
	endtask

	// never let an event read a transition entry that was never written
	task automatic send_event(logic [3:0] ev, logic [15:0] flags);
		beat_t b;
		int hop;
		hop = sb.first_unwritten_hop();
		while (hop >= 0) begin
			load_trans(6'(hop), pick_event(), pick_guard(), pick_action(), pick_state());
			hop = sb.first_unwritten_hop();
		end
		b = noise_beat();
		b.mode = MODE_EVENT;
		b.event_req = ev;
		b.guard_flags = flags;
		send_beat(b);
	endtask

	// sender holds off until every due beat has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic directed_beats();
		int m;
		// event on a state that was never loaded
		send_event(4'd0, 16'h0000);
		// unused modes only ack
		for (m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) begin
			send_spare(3'(m));
		end
		// present state with zero transitions
		load_state(4'd0, 1'b1, 6'd62, 4'd0);
		send_event(4'd15, 16'hFFFF);
		// entry and exit actions, extremes included
		load_actions(4'd0, 8'hFF, 8'h01);
		load_actions(4'd3, 8'h80, 8'h00);
		load_actions(4'd15, 8'h00, 8'hAA);
		// transitions across the address wrap: plain, top guard, unknown guard, guard one
		load_trans(6'd62, 4'd15, 5'd0, 8'hFF, 4'd3);
		load_trans(6'd63, 4'd15, 5'd16, 8'h00, 4'd15);
		load_trans(6'd0, 4'd15, 5'd17, 8'h55, 4'd1);
		load_trans(6'd1, 4'd0, 5'd1, 8'h00, 4'd0);
		load_state(4'd0, 1'b1, 6'd62, 4'd4);
		// two matches, last one wins, exit action of the start state both times
		send_event(4'd15, 16'hFFFF);
		// state 15 is absent
		send_event(4'd3, 16'hFFFF);
		// top guard fails, only the first match fires
		set_state(4'd0);
		send_event(4'd15, 16'h7FFF);
		// self transition through guard one, then an event nobody listens for
		set_state(4'd0);
		send_event(4'd0, 16'h0001);
		send_event(4'd9, 16'h0000);
		// absent entry at the top of the table
		load_state(4'd5, 1'b0, 6'd63, 4'd8);
		// count past the per-state limit walks only the limit
		load_state(4'd0, 1'b1, 6'd62, 4'd15);
		send_event(4'd15, 16'h0000);
		set_state(4'd15);
	endtask

	// one random beat or a short well-formed sequence
	task automatic random_step();
		int r;
		int n;
		int i;
		logic [3:0] sid;
		logic [5:0] base;
		logic [3:0] cnt;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			send_event(pick_event(), pick_flags());
		end else if (r < 60) begin
			// build a whole state: entry, its transitions, its actions
			sid = pick_state();
			base = 6'($urandom);
			n = $urandom_range(1, 4);
			load_state(sid, 1'b1, base, 4'(n));
			for (i = 0; i < n; i++) begin
				load_trans(base + 6'(i), pick_event(), pick_guard(), pick_action(),
					pick_state());
			end
			load_actions(sid, pick_action(), pick_action());
		end else if (r < 68) begin
			n = $urandom_range(0, 99);
			if (n < 8) begin
				cnt = 4'd0;
			end else if (n < 85) begin
				cnt = 4'($urandom_range(1, MAX_PER_STATE_DEF));
			end else begin
				cnt = 4'($urandom_range(MAX_PER_STATE_DEF + 1, 15));
			end
			load_state(pick_state(), ($urandom_range(0, 99) < 85), 6'($urandom), cnt);
		end else if (r < 78) begin
			load_trans(6'($urandom), pick_event(), pick_guard(), pick_action(), pick_state());
		end else if (r < 87) begin
			load_actions(pick_state(), pick_action(), pick_action());
		end else if (r < 95) begin
			set_state(pick_state());
		end else begin
			send_spare(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)));
		end
	endtask

	task automatic random_beats();
		int unsigned start;
		int phase;
		start = beats_sent;
		phase = 0;
		while (beats_sent - start < RANDOM_BEATS) begin
			// swap the idle rates, then run with no idling at all
			if (phase == 0 && beats_sent - start >= RANDOM_BEATS / 3) begin
				drain();
				send_idle_pct = 49;
				recv_idle_pct = 24;
				phase = 1;
			end else if (phase == 1 && beats_sent - start >= 2 * RANDOM_BEATS / 3) begin
				drain();
				send_idle_pct = 0;
				recv_idle_pct = 0;
				phase = 2;
			end
			random_step();
		end
	endtask

	initial begin
		sb = new();
		send_idle_pct = 24;
		recv_idle_pct = 49;
		// reset held low from time zero, released on an edge
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_beats();
		drain();
		random_beats();
		drain();
		// stray beats after the last due one still get flagged
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("table_driven_fsm_engine test passed");
		end else begin
			$display("table_driven_fsm_engine test failed");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/tdfe_pkg.sv
rtl/tdfe_ram.sv
rtl/tdfe_seq.sv
rtl/table_driven_fsm_engine.sv
tb/tb_table_driven_fsm_engine.sv
